>>> sv/gnss_pps_time_discipline_top_defines.svh
// ----------------------------------------------------------------------------
// gnss_pps_time_discipline_top_defines
// assertion macros shared by the time discipline rtl
// ----------------------------------------------------------------------------
`ifndef GNSS_PPS_TIME_DISCIPLINE_TOP_DEFINES_SVH
`define GNSS_PPS_TIME_DISCIPLINE_TOP_DEFINES_SVH

// same-cycle implication, expects clk and rst_n in scope
`define GPTD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gptd assertion failed");

// next-cycle implication, expects clk and rst_n in scope
`define GPTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gptd assertion failed");

`endif

>>> sv/gptd_pkg.sv
// ----------------------------------------------------------------------------
// gptd_pkg
// types, constants and the date conversion micro-program
// ----------------------------------------------------------------------------
package gptd_pkg;

  localparam logic [31:0] TICK_MIN_MS    = 32'd30;
  localparam logic [31:0] SECOND_MS      = 32'd1000;
  localparam logic [31:0] FIX_MAX_AGE_MS = 32'd2500;
  localparam logic [31:0] FIX_MIN_GAP_MS = 32'd400;

  localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [11:0] TWO_DIGIT_MAX  = 12'd99;
  localparam logic [11:0] YEARS_TO_2000  = 12'd30;
  localparam logic [11:0] EPOCH_YEAR_M1  = 12'd1969;
  localparam logic [9:0]  LEAP_BIAS      = 10'd492;
  localparam logic [7:0]  OFF_PAST_2100  = 8'd131;
  localparam logic [7:0]  OFF_PAST_2200  = 8'd231;
  localparam logic [7:0]  OFF_YEAR_2100  = 8'd130;
  localparam logic [7:0]  OFF_YEAR_2200  = 8'd230;
  localparam logic [3:0]  MONTH_FEB      = 4'd2;
  localparam logic [3:0]  MONTH_DEC      = 4'd12;

  localparam logic       SYNC_ENABLE_RST = 1'b1;
  localparam logic [9:0] NMEA_OFFSET_RST = 10'd100;
  localparam logic [7:0] SLOT_ADJUST_RST = 8'd25;

  typedef enum logic [1:0] {
    CFG_SYNC_ENABLE = 2'd0,
    CFG_NMEA_OFFSET = 2'd1,
    CFG_SLOT_ADJUST = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_FREE = 2'd1,
    EV_SYNC = 2'd2
  } event_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GAP,
    ST_GAP_CMP,
    ST_COMMIT,
    ST_PPS_CMP,
    ST_PPS_SHIFT,
    ST_CORR,
    ST_PPS_ADD,
    ST_NMEA,
    ST_AGE_CMP,
    ST_BASE_CMP,
    ST_EDGE_CMP,
    ST_GAP_SUM,
    ST_GAP_FIX,
    ST_FREE_SUM,
    ST_FREE_CMP,
    ST_FREE_INC,
    ST_LATE_SUM,
    ST_LATE_CMP,
    ST_LATE_ADD,
    ST_ROUND_SUM,
    ST_ROUND_CMP,
    ST_DATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] fix_age_ms;
    logic        fix_valid;
    logic [31:0] pps_mark_ms;
    logic [11:0] fix_year;
    logic [3:0]  fix_month;
    logic [4:0]  fix_day;
    logic [4:0]  fix_hour;
    logic [5:0]  fix_minute;
    logic [5:0]  fix_second;
  } item_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [4:0]  shamt;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        carry;
  } alu_rsp_t;

  typedef struct packed {
    logic [7:0] off;
    logic [6:0] leaps;
    logic [8:0] mdays;
  } date_terms_t;

  typedef enum logic [3:0] {
    SRC_OFF,
    SRC_LEAPS,
    SRC_MDAYS,
    SRC_DAY,
    SRC_ONE,
    SRC_DAYS,
    SRC_HOUR,
    SRC_MINUTE,
    SRC_SECOND,
    SRC_ROUND
  } src_t;

  typedef struct packed {
    src_t       src;
    logic [4:0] shamt;
    logic       sub;
    logic       save;
  } uop_t;

  localparam logic [4:0] DATE_LAST = 5'd24;

  // days = off*365 + leaps + mdays + day - 1, then
  // days*86400 + hour*3600 + minute*60 + second + round, all by shift-add
  function automatic uop_t date_uop(input logic [4:0] idx);
    uop_t u;
    case (idx)
      5'd0:    u = '{SRC_OFF,    5'd8,  1'b0, 1'b0};
      5'd1:    u = '{SRC_OFF,    5'd6,  1'b0, 1'b0};
      5'd2:    u = '{SRC_OFF,    5'd5,  1'b0, 1'b0};
      5'd3:    u = '{SRC_OFF,    5'd3,  1'b0, 1'b0};
      5'd4:    u = '{SRC_OFF,    5'd2,  1'b0, 1'b0};
      5'd5:    u = '{SRC_OFF,    5'd0,  1'b0, 1'b0};
      5'd6:    u = '{SRC_LEAPS,  5'd0,  1'b0, 1'b0};
      5'd7:    u = '{SRC_MDAYS,  5'd0,  1'b0, 1'b0};
      5'd8:    u = '{SRC_DAY,    5'd0,  1'b0, 1'b0};
      5'd9:    u = '{SRC_ONE,    5'd0,  1'b1, 1'b1};
      5'd10:   u = '{SRC_DAYS,   5'd16, 1'b0, 1'b0};
      5'd11:   u = '{SRC_DAYS,   5'd14, 1'b0, 1'b0};
      5'd12:   u = '{SRC_DAYS,   5'd12, 1'b0, 1'b0};
      5'd13:   u = '{SRC_DAYS,   5'd8,  1'b0, 1'b0};
      5'd14:   u = '{SRC_DAYS,   5'd7,  1'b0, 1'b0};
      5'd15:   u = '{SRC_HOUR,   5'd11, 1'b0, 1'b0};
      5'd16:   u = '{SRC_HOUR,   5'd10, 1'b0, 1'b0};
      5'd17:   u = '{SRC_HOUR,   5'd9,  1'b0, 1'b0};
      5'd18:   u = '{SRC_HOUR,   5'd4,  1'b0, 1'b0};
      5'd19:   u = '{SRC_MINUTE, 5'd5,  1'b0, 1'b0};
      5'd20:   u = '{SRC_MINUTE, 5'd4,  1'b0, 1'b0};
      5'd21:   u = '{SRC_MINUTE, 5'd3,  1'b0, 1'b0};
      5'd22:   u = '{SRC_MINUTE, 5'd2,  1'b0, 1'b0};
      5'd23:   u = '{SRC_SECOND, 5'd0,  1'b0, 1'b0};
      5'd24:   u = '{SRC_ROUND,  5'd0,  1'b0, 1'b0};
      default: u = '{SRC_ROUND,  5'd0,  1'b0, 1'b0};
    endcase
    return u;
  endfunction

  // days in the months before month m of a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> sv/gptd_in_if.sv
// ----------------------------------------------------------------------------
// gptd_in_if
// tick channel: counter value, fix age and flags, pps edge, fix date and time
// ----------------------------------------------------------------------------
interface gptd_in_if ();
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [31:0] fix_age_ms;
  logic        fix_valid;
  logic [31:0] pps_mark_ms;
  logic [11:0] fix_year;
  logic [3:0]  fix_month;
  logic [4:0]  fix_day;
  logic [4:0]  fix_hour;
  logic [5:0]  fix_minute;
  logic [5:0]  fix_second;

  modport source (
    output valid, now_ms, fix_age_ms, fix_valid, pps_mark_ms,
           fix_year, fix_month, fix_day, fix_hour, fix_minute, fix_second,
    input  ready
  );

  modport sink (
    input  valid, now_ms, fix_age_ms, fix_valid, pps_mark_ms,
           fix_year, fix_month, fix_day, fix_hour, fix_minute, fix_second,
    output ready
  );
endinterface

>>> sv/gptd_out_if.sv
// ----------------------------------------------------------------------------
// gptd_out_if
// result channel: seconds count, second boundary reference, event code
// ----------------------------------------------------------------------------
interface gptd_out_if ();
  logic        valid;
  logic        ready;
  logic [31:0] unix_seconds;
  logic [31:0] reference_ms;
  logic [1:0]  event_res;

  modport source (
    output valid, unix_seconds, reference_ms, event_res,
    input  ready
  );

  modport sink (
    input  valid, unix_seconds, reference_ms, event_res,
    output ready
  );
endinterface

>>> sv/gptd_alu.sv
// ----------------------------------------------------------------------------
// gptd_alu
// shared 32-bit add/subtract unit with operand shifter and carry out
// ----------------------------------------------------------------------------
module gptd_alu import gptd_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [31:0] b_shift;
  logic [31:0] b_eff;
  logic [32:0] sum;

  assign b_shift = req_i.b << req_i.shamt;
  assign b_eff   = req_i.sub ? ~b_shift : b_shift;
  // for a subtract, carry high means a >= b
  assign sum     = {1'b0, req_i.a} + {1'b0, b_eff} + {32'd0, req_i.sub};

  assign rsp_o.res   = sum[31:0];
  assign rsp_o.carry = sum[32];

endmodule

>>> sv/gptd_date_terms.sv
// ----------------------------------------------------------------------------
// gptd_date_terms
// narrow calendar terms: year offset from epoch, leap days, days before month
// ----------------------------------------------------------------------------
module gptd_date_terms import gptd_pkg::*; (
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  output date_terms_t terms_o
);

  logic [11:0] yr_diff;
  logic [11:0] yr_short;
  logic [7:0]  off;
  logic [11:0] q_base;
  logic [9:0]  quarter;
  logic [9:0]  leap_cnt;
  logic        leap_year;
  logic [3:0]  month_c;

  assign yr_diff  = year_i - EPOCH_YEAR;
  assign yr_short = year_i + YEARS_TO_2000;
  assign off      = (year_i > TWO_DIGIT_MAX) ? yr_diff[7:0] : yr_short[7:0];

  // multiples of four in [1970, 1970+off), less the two skipped centuries
  assign q_base   = EPOCH_YEAR_M1 + {4'd0, off};
  assign quarter  = q_base[11:2];
  assign leap_cnt = quarter - LEAP_BIAS
                  - {9'd0, (off >= OFF_PAST_2100)}
                  - {9'd0, (off >= OFF_PAST_2200)};

  assign leap_year = (off[1:0] == 2'd2) && (off != OFF_YEAR_2100) && (off != OFF_YEAR_2200);
  assign month_c   = (month_i > MONTH_DEC) ? MONTH_DEC : month_i;

  assign terms_o.off   = off;
  assign terms_o.leaps = leap_cnt[6:0];
  assign terms_o.mdays = cum_days(month_c) + {8'd0, ((month_c > MONTH_FEB) && leap_year)};

endmodule

>>> sv/gnss_pps_time_discipline_top.sv
// ----------------------------------------------------------------------------
// gnss_pps_time_discipline_top
// flow: a tick too soon or with sync off goes straight to the result; a
//   free-run tick adds the free-run steps, a resync also runs the date program
// the sequencer walks all arithmetic through the one shared adder, so a new tick
//   is taken only once the last result is registered for output; ready only while idle
// reset: rst_n synchronous active low, clears time state, loads register defaults
// ----------------------------------------------------------------------------
`include "gnss_pps_time_discipline_top_defines.svh"

module gnss_pps_time_discipline_top import gptd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [9:0]       cfg_wdata,
  gptd_in_if.sink          in_ch,
  gptd_out_if.source       out_ch
);

  state_t      state_r, state_nxt;
  item_t       item_r, item_nxt, in_item;

  logic        sync_en_r;
  logic [9:0]  nmea_ofs_r;
  logic [7:0]  slot_adj_r;

  logic [31:0] last_tick_r, last_tick_nxt;
  logic [31:0] last_fix_r, last_fix_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] ref_r, ref_nxt;
  logic [31:0] secs_r, secs_nxt;

  logic [31:0] tmp_r, tmp_nxt;
  logic [31:0] commit_r, commit_nxt;
  logic [31:0] pps_r, pps_nxt;
  logic [31:0] newtime_r, newtime_nxt;
  logic [31:0] corr_r, corr_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] days_r, days_nxt;
  logic        fix_ok_r, fix_ok_nxt;
  logic        round_r, round_nxt;
  event_t      event_r, event_nxt;
  logic [4:0]  step_r, step_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_secs_r, out_secs_nxt;
  logic [31:0] out_ref_r, out_ref_nxt;
  event_t      out_event_r, out_event_nxt;

  logic        in_ready;
  logic        in_fire;
  logic        out_free;

  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  date_terms_t terms;
  uop_t        uop;
  logic [31:0] date_opnd;

  gptd_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  gptd_date_terms u_date_terms (
    .year_i  (item_r.fix_year),
    .month_i (item_r.fix_month),
    .terms_o (terms)
  );

  assign in_ready    = (state_r == ST_IDLE);
  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.unix_seconds = out_secs_r;
  assign out_ch.reference_ms = out_ref_r;
  assign out_ch.event_res    = out_event_r;

  assign in_item.now_ms      = in_ch.now_ms;
  assign in_item.fix_age_ms  = in_ch.fix_age_ms;
  assign in_item.fix_valid   = in_ch.fix_valid;
  assign in_item.pps_mark_ms = in_ch.pps_mark_ms;
  assign in_item.fix_year    = in_ch.fix_year;
  assign in_item.fix_month   = in_ch.fix_month;
  assign in_item.fix_day     = in_ch.fix_day;
  assign in_item.fix_hour    = in_ch.fix_hour;
  assign in_item.fix_minute  = in_ch.fix_minute;
  assign in_item.fix_second  = in_ch.fix_second;

  assign uop = date_uop(step_r);

  always_comb begin
    case (uop.src)
      SRC_OFF:    date_opnd = {24'd0, terms.off};
      SRC_LEAPS:  date_opnd = {25'd0, terms.leaps};
      SRC_MDAYS:  date_opnd = {23'd0, terms.mdays};
      SRC_DAY:    date_opnd = {27'd0, item_r.fix_day};
      SRC_ONE:    date_opnd = 32'd1;
      SRC_DAYS:   date_opnd = days_r;
      SRC_HOUR:   date_opnd = {27'd0, item_r.fix_hour};
      SRC_MINUTE: date_opnd = {26'd0, item_r.fix_minute};
      SRC_SECOND: date_opnd = {26'd0, item_r.fix_second};
      SRC_ROUND:  date_opnd = {31'd0, round_r};
      default:    date_opnd = 32'd0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_en_r  <= SYNC_ENABLE_RST;
      nmea_ofs_r <= NMEA_OFFSET_RST;
      slot_adj_r <= SLOT_ADJUST_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SYNC_ENABLE: sync_en_r  <= cfg_wdata[0];
        CFG_NMEA_OFFSET: nmea_ofs_r <= cfg_wdata;
        CFG_SLOT_ADJUST: slot_adj_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_fire) state_nxt = ST_GAP;
      ST_GAP:       state_nxt = ST_GAP_CMP;
      ST_GAP_CMP:   state_nxt = (alu_rsp.carry && sync_en_r) ? ST_COMMIT : ST_OUT;
      ST_COMMIT: begin
        if (!item_r.fix_valid) begin
          state_nxt = ST_FREE_SUM;
        end else if (item_r.pps_mark_ms != 32'd0) begin
          state_nxt = ST_PPS_CMP;
        end else begin
          state_nxt = ST_NMEA;
        end
      end
      ST_PPS_CMP:   state_nxt = alu_rsp.carry ? ST_PPS_ADD : ST_PPS_SHIFT;
      ST_PPS_SHIFT: state_nxt = ST_CORR;
      ST_CORR:      state_nxt = ST_PPS_ADD;
      ST_PPS_ADD:   state_nxt = ST_AGE_CMP;
      ST_NMEA:      state_nxt = ST_AGE_CMP;
      ST_AGE_CMP:   state_nxt = ST_BASE_CMP;
      ST_BASE_CMP:  state_nxt = ST_EDGE_CMP;
      ST_EDGE_CMP:  state_nxt = ST_GAP_SUM;
      ST_GAP_SUM:   state_nxt = ST_GAP_FIX;
      ST_GAP_FIX:   state_nxt = (fix_ok_r && !alu_rsp.carry) ? ST_LATE_SUM : ST_FREE_SUM;
      ST_FREE_SUM:  state_nxt = ST_FREE_CMP;
      ST_FREE_CMP:  state_nxt = ((ref_r != 32'd0) && alu_rsp.carry) ? ST_FREE_INC : ST_OUT;
      ST_FREE_INC:  state_nxt = ST_OUT;
      ST_LATE_SUM:  state_nxt = ST_LATE_CMP;
      ST_LATE_CMP:  state_nxt = ((pps_r != 32'd0) && !alu_rsp.carry) ? ST_LATE_ADD
                                                                   : ST_ROUND_SUM;
      ST_LATE_ADD:  state_nxt = ST_ROUND_SUM;
      ST_ROUND_SUM: state_nxt = ST_ROUND_CMP;
      ST_ROUND_CMP: state_nxt = ST_DATE;
      ST_DATE:      if (step_r == DATE_LAST) state_nxt = ST_OUT;
      ST_OUT:       if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath: operand selection for the shared adder and register updates
  always_comb begin
    alu_req       = '{a: 32'd0, b: 32'd0, shamt: 5'd0, sub: 1'b0};
    item_nxt      = item_r;
    last_tick_nxt = last_tick_r;
    last_fix_nxt  = last_fix_r;
    base_nxt      = base_r;
    ref_nxt       = ref_r;
    secs_nxt      = secs_r;
    tmp_nxt       = tmp_r;
    commit_nxt    = commit_r;
    pps_nxt       = pps_r;
    newtime_nxt   = newtime_r;
    corr_nxt      = corr_r;
    acc_nxt       = acc_r;
    days_nxt      = days_r;
    fix_ok_nxt    = fix_ok_r;
    round_nxt     = round_r;
    event_nxt     = event_r;
    step_nxt      = step_r;
    out_secs_nxt  = out_secs_r;
    out_ref_nxt   = out_ref_r;
    out_event_nxt = out_event_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          item_nxt  = in_item;
          event_nxt = EV_NONE;
        end
      end
      ST_GAP: begin
        alu_req = '{a: item_r.now_ms, b: last_tick_r, shamt: 5'd0, sub: 1'b1};
        tmp_nxt = alu_rsp.res;
      end
      ST_GAP_CMP: begin
        alu_req = '{a: tmp_r, b: TICK_MIN_MS, shamt: 5'd0, sub: 1'b1};
        if (alu_rsp.carry) last_tick_nxt = item_r.now_ms;
      end
      ST_COMMIT: begin
        alu_req    = '{a: item_r.now_ms, b: item_r.fix_age_ms, shamt: 5'd0, sub: 1'b1};
        commit_nxt = alu_rsp.res;
      end
      ST_PPS_CMP: begin
        alu_req  = '{a: commit_r, b: item_r.pps_mark_ms, shamt: 5'd0, sub: 1'b1};
        corr_nxt = alu_rsp.res;
        pps_nxt  = item_r.pps_mark_ms;
      end
      ST_PPS_SHIFT: begin
        // commit before the edge: the edge belongs to the previous second
        alu_req = '{a: pps_r, b: SECOND_MS, shamt: 5'd0, sub: 1'b1};
        pps_nxt = alu_rsp.res;
      end
      ST_CORR: begin
        alu_req  = '{a: commit_r, b: pps_r, shamt: 5'd0, sub: 1'b1};
        corr_nxt = alu_rsp.res;
      end
      ST_PPS_ADD: begin
        alu_req     = '{a: pps_r, b: {24'd0, slot_adj_r}, shamt: 5'd0, sub: 1'b0};
        newtime_nxt = alu_rsp.res;
      end
      ST_NMEA: begin
        alu_req     = '{a: commit_r, b: {22'd0, nmea_ofs_r}, shamt: 5'd0, sub: 1'b1};
        newtime_nxt = alu_rsp.res;
        corr_nxt    = {22'd0, nmea_ofs_r};
        pps_nxt     = 32'd0;
      end
      ST_AGE_CMP: begin
        alu_req    = '{a: item_r.fix_age_ms, b: FIX_MAX_AGE_MS, shamt: 5'd0, sub: 1'b1};
        fix_ok_nxt = !alu_rsp.carry;
      end
      ST_BASE_CMP: begin
        alu_req    = '{a: base_r, b: newtime_r, shamt: 5'd0, sub: 1'b1};
        fix_ok_nxt = fix_ok_r && !alu_rsp.carry;
      end
      ST_EDGE_CMP: begin
        alu_req    = '{a: pps_r, b: commit_r, shamt: 5'd0, sub: 1'b1};
        fix_ok_nxt = fix_ok_r && ((pps_r == 32'd0) || !alu_rsp.carry);
      end
      ST_GAP_SUM: begin
        alu_req = '{a: last_fix_r, b: FIX_MIN_GAP_MS, shamt: 5'd0, sub: 1'b0};
        tmp_nxt = alu_rsp.res;
      end
      ST_GAP_FIX: begin
        alu_req = '{a: tmp_r, b: commit_r, shamt: 5'd0, sub: 1'b1};
        if (fix_ok_r && !alu_rsp.carry) last_fix_nxt = commit_r;
      end
      ST_FREE_SUM: begin
        alu_req = '{a: ref_r, b: SECOND_MS, shamt: 5'd0, sub: 1'b0};
        tmp_nxt = alu_rsp.res;
      end
      ST_FREE_CMP: begin
        alu_req = '{a: item_r.now_ms, b: tmp_r, shamt: 5'd0, sub: 1'b1};
        if ((ref_r != 32'd0) && alu_rsp.carry) ref_nxt = tmp_r;
      end
      ST_FREE_INC: begin
        alu_req   = '{a: secs_r, b: 32'd1, shamt: 5'd0, sub: 1'b0};
        secs_nxt  = alu_rsp.res;
        event_nxt = EV_FREE;
      end
      ST_LATE_SUM: begin
        alu_req = '{a: pps_r, b: SECOND_MS, shamt: 5'd0, sub: 1'b0};
        tmp_nxt = alu_rsp.res;
      end
      ST_LATE_CMP: begin
        alu_req = '{a: tmp_r, b: item_r.now_ms, shamt: 5'd0, sub: 1'b1};
      end
      ST_LATE_ADD: begin
        alu_req     = '{a: newtime_r, b: SECOND_MS, shamt: 5'd0, sub: 1'b0};
        newtime_nxt = alu_rsp.res;
      end
      ST_ROUND_SUM: begin
        alu_req  = '{a: item_r.fix_age_ms, b: corr_r, shamt: 5'd0, sub: 1'b0};
        tmp_nxt  = alu_rsp.res;
        ref_nxt  = newtime_r;
        base_nxt = newtime_r;
      end
      ST_ROUND_CMP: begin
        alu_req   = '{a: tmp_r, b: SECOND_MS, shamt: 5'd0, sub: 1'b1};
        round_nxt = alu_rsp.carry;
        acc_nxt   = 32'd0;
        step_nxt  = 5'd0;
      end
      ST_DATE: begin
        alu_req = '{a: acc_r, b: date_opnd, shamt: uop.shamt, sub: uop.sub};
        if (uop.save) begin
          days_nxt = alu_rsp.res;
          acc_nxt  = 32'd0;
        end else begin
          acc_nxt = alu_rsp.res;
        end
        if (step_r == DATE_LAST) begin
          secs_nxt  = alu_rsp.res;
          event_nxt = EV_SYNC;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_secs_nxt  = secs_r;
          out_ref_nxt   = ref_r;
          out_event_nxt = event_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_tick_r <= 32'd0;
      last_fix_r  <= 32'd0;
      base_r      <= 32'd0;
      ref_r       <= 32'd0;
      secs_r      <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_tick_r <= last_tick_nxt;
      last_fix_r  <= last_fix_nxt;
      base_r      <= base_nxt;
      ref_r       <= ref_nxt;
      secs_r      <= secs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    tmp_r       <= tmp_nxt;
    commit_r    <= commit_nxt;
    pps_r       <= pps_nxt;
    newtime_r   <= newtime_nxt;
    corr_r      <= corr_nxt;
    acc_r       <= acc_nxt;
    days_r      <= days_nxt;
    fix_ok_r    <= fix_ok_nxt;
    round_r     <= round_nxt;
    event_r     <= event_nxt;
    step_r      <= step_nxt;
    out_secs_r  <= out_secs_nxt;
    out_ref_r   <= out_ref_nxt;
    out_event_r <= out_event_nxt;
  end

  `GPTD_ASSERT_NEXT(a_busy_after_beat, in_fire, !in_ready)
  `GPTD_ASSERT_IMPL(a_step_in_program, state_r == ST_DATE, step_r <= DATE_LAST)
  `GPTD_ASSERT_IMPL(a_result_from_out, $rose(out_valid_r), $past(state_r) == ST_OUT)
  `GPTD_ASSERT_IMPL(a_tick_time_update, !$stable(last_tick_r), $past(state_r) == ST_GAP_CMP)

endmodule

>>> sim/gptd_time_checker.sv
// ----------------------------------------------------------------------------
// gptd_time_checker
// watches the tick, result and register ports, keeps its own disciplined
// clock and compares every result beat with the reading it predicts
// ----------------------------------------------------------------------------
module gptd_time_checker import gptd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  gptd_in_if          in_ch,
  gptd_out_if         out_ch,
  output int unsigned pending,
  output int unsigned fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] unix_seconds;
    logic [31:0] reference_ms;
    event_t      event_res;
  } clock_reading_t;

  clock_reading_t readings_due[$];
  int unsigned    mismatches;
  int unsigned    waiting;

  // register mirror
  logic        sync_on;
  logic [9:0]  nmea_off;
  logic [7:0]  slot_adj;

  // clock state
  logic [31:0] last_tick_mark;
  logic [31:0] last_commit;
  logic [31:0] base_mark;
  logic [31:0] ref_mark;
  logic [31:0] unix_count;

  assign pending    = waiting;
  assign fail_count = mismatches;

  initial begin
    mismatches = 0;
    waiting    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: time checker: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got, want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_len(input int unsigned m);
    case (m)
      2:             return 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // gregorian date to seconds since 1970, everything wraps at 32 bits
  function automatic logic [31:0] fix_to_unix(input item_t t);
    int unsigned off;
    int unsigned days;
    int unsigned mon;
    days = 0;
    if (t.fix_year > TWO_DIGIT_MAX) begin
      off = (32'(t.fix_year) - 32'(EPOCH_YEAR)) & 32'hFF;
    end else begin
      off = 32'(t.fix_year) + 32'(YEARS_TO_2000);
    end
    for (int unsigned y = 0; y < off; y++) begin
      days += leap_year(32'(EPOCH_YEAR) + y) ? 366 : 365;
    end
    mon = (t.fix_month > MONTH_DEC) ? 32'(MONTH_DEC) : 32'(t.fix_month);
    for (int unsigned m = 1; m < mon; m++) begin
      days += month_len(m);
      if (m == 32'(MONTH_FEB) && leap_year(32'(EPOCH_YEAR) + off)) days += 1;
    end
    days = days + 32'(t.fix_day) - 32'd1;
    return days * 32'd86400 + 32'(t.fix_hour) * 32'd3600
         + 32'(t.fix_minute) * 32'd60 + 32'(t.fix_second);
  endfunction

  task automatic advance_clock(input item_t t, output clock_reading_t r);
    logic [31:0] commit;
    logic [31:0] pps;
    logic [31:0] newtime;
    logic [31:0] corr;
    logic        fresh;
    event_t      ev;
    ev      = EV_NONE;
    fresh   = 1'b0;
    newtime = '0;
    corr    = '0;
    pps     = t.pps_mark_ms;
    if (t.now_ms - last_tick_mark >= TICK_MIN_MS) begin
      last_tick_mark = t.now_ms;
      if (sync_on) begin
        commit = t.now_ms - t.fix_age_ms;
        if (t.fix_valid) begin
          if (pps != 0) begin
            // commit ahead of the edge means the edge belongs to the second before
            if (commit < pps) pps = pps - SECOND_MS;
            newtime = pps + 32'(slot_adj);
            corr    = commit - pps;
          end else begin
            corr    = 32'(nmea_off);
            newtime = commit - corr;
          end
          if (t.fix_age_ms < FIX_MAX_AGE_MS && newtime > base_mark &&
              (pps == 0 || commit > pps) && commit > last_commit + FIX_MIN_GAP_MS) begin
            fresh       = 1'b1;
            last_commit = commit;
          end
        end
        if (!fresh) begin
          if (ref_mark != 0 && t.now_ms >= ref_mark + SECOND_MS) begin
            unix_count = unix_count + 32'd1;
            ref_mark   = ref_mark + SECOND_MS;
            ev         = EV_FREE;
          end
        end else begin
          if (pps != 0 && t.now_ms > pps + SECOND_MS) newtime = newtime + SECOND_MS;
          ref_mark   = newtime;
          base_mark  = newtime;
          unix_count = fix_to_unix(t);
          if (t.fix_age_ms + corr >= SECOND_MS) unix_count = unix_count + 32'd1;
          ev         = EV_SYNC;
        end
      end
    end
    r.unix_seconds = unix_count;
    r.reference_ms = ref_mark;
    r.event_res    = ev;
  endtask

  always @(posedge clk) begin
    clock_reading_t want;
    item_t          t;
    if (!rst_n) begin
      sync_on        = SYNC_ENABLE_RST;
      nmea_off       = NMEA_OFFSET_RST;
      slot_adj       = SLOT_ADJUST_RST;
      last_tick_mark = '0;
      last_commit    = '0;
      base_mark      = '0;
      ref_mark       = '0;
      unix_count     = '0;
      readings_due.delete();
      waiting        = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYNC_ENABLE: sync_on  = cfg_wdata[0];
          CFG_NMEA_OFFSET: nmea_off = cfg_wdata;
          CFG_SLOT_ADJUST: slot_adj = cfg_wdata[7:0];
          default: ;
        endcase
      end
      // result beat first: it belongs to an older tick than any tick taken now
      if (out_ch.valid && out_ch.ready) begin
        if (readings_due.size() == 0) begin
          report_mismatch("result beat with no reading expected");
        end else begin
          want = readings_due.pop_front();
          compare_field("unix_seconds", out_ch.unix_seconds, want.unix_seconds);
          compare_field("reference_ms", out_ch.reference_ms, want.reference_ms);
          compare_field("event_res", 32'(out_ch.event_res), 32'(want.event_res));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        t.now_ms      = in_ch.now_ms;
        t.fix_age_ms  = in_ch.fix_age_ms;
        t.fix_valid   = in_ch.fix_valid;
        t.pps_mark_ms = in_ch.pps_mark_ms;
        t.fix_year    = in_ch.fix_year;
        t.fix_month   = in_ch.fix_month;
        t.fix_day     = in_ch.fix_day;
        t.fix_hour    = in_ch.fix_hour;
        t.fix_minute  = in_ch.fix_minute;
        t.fix_second  = in_ch.fix_second;
        advance_clock(t, want);
        readings_due.push_back(want);
      end
      waiting = readings_due.size();
    end
  end

endmodule

>>> sim/tb_gnss_pps_time_discipline_top.sv
// ----------------------------------------------------------------------------
// tb_gnss_pps_time_discipline_top
// drives ticks and register writes into the time discipline block with
// random gaps and result back-pressure; the checker beside it predicts
// every result, this top only makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module tb_gnss_pps_time_discipline_top import gptd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 60;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_wdata;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_count;

  logic [31:0] clock_ms;
  bit          quiet;
  bit          hold_rx;

  gptd_in_if  tick_ch ();
  gptd_out_if time_ch ();

  gnss_pps_time_discipline_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (tick_ch),
    .out_ch    (time_ch)
  );

  gptd_time_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (tick_ch),
    .out_ch     (time_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_gnss_pps_time_discipline_top NOT OK");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic item_t mk_tick(input logic [31:0] now, age, input logic valid,
                                    input logic [31:0] pps, input logic [11:0] yr,
                                    input logic [3:0] mo, input logic [4:0] dd, hh,
                                    input logic [5:0] mi, ss);
    item_t t;
    t.now_ms      = now;
    t.fix_age_ms  = age;
    t.fix_valid   = valid;
    t.pps_mark_ms = pps;
    t.fix_year    = yr;
    t.fix_month   = mo;
    t.fix_day     = dd;
    t.fix_hour    = hh;
    t.fix_minute  = mi;
    t.fix_second  = ss;
    return t;
  endfunction

  // valid stays high into the next beat when no gap is drawn
  task automatic push_tick(input item_t t);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.now_ms      <= t.now_ms;
    tick_ch.fix_age_ms  <= t.fix_age_ms;
    tick_ch.fix_valid   <= t.fix_valid;
    tick_ch.pps_mark_ms <= t.pps_mark_ms;
    tick_ch.fix_year    <= t.fix_year;
    tick_ch.fix_month   <= t.fix_month;
    tick_ch.fix_day     <= t.fix_day;
    tick_ch.fix_hour    <= t.fix_hour;
    tick_ch.fix_minute  <= t.fix_minute;
    tick_ch.fix_second  <= t.fix_second;
    tick_ch.valid       <= 1'b1;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  // first let the checker count the last tick taken, then wait for it to drain
  task automatic drain();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(input logic sync_on, input logic [9:0] nmea,
                           input logic [7:0] slot);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_ENABLE;
    cfg_wdata <= {9'd0, sync_on};
    @(posedge clk);
    cfg_index <= CFG_NMEA_OFFSET;
    cfg_wdata <= nmea;
    @(posedge clk);
    cfg_index <= CFG_SLOT_ADJUST;
    cfg_wdata <= {2'd0, slot};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly plausible fix sequences on an advancing counter, plus noise
  // and ticks that come too soon
  task automatic make_tick(output item_t t);
    int unsigned kind;
    int unsigned sel;
    logic [31:0] commit;
    kind = $urandom_range(0, 99);
    sel  = $urandom_range(0, 9);
    if (sel < 4)      t.fix_year = 12'($urandom_range(0, 99));
    else if (sel < 8) t.fix_year = 12'($urandom_range(1970, 2099));
    else              t.fix_year = 12'($urandom_range(0, 4095));
    t.fix_month  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 12));
    t.fix_day    = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 31));
    t.fix_hour   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(0, 23));
    t.fix_minute = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 59));
    t.fix_second = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 59));
    t.fix_valid  = ($urandom_range(0, 9) != 0);
    if (kind < 12) begin
      t.now_ms      = $urandom;
      t.fix_age_ms  = $urandom;
      t.fix_valid   = 1'($urandom_range(0, 1));
      t.pps_mark_ms = $urandom;
      t.fix_year    = 12'($urandom);
      t.fix_month   = 4'($urandom);
      t.fix_day     = 5'($urandom);
      t.fix_hour    = 5'($urandom);
      t.fix_minute  = 6'($urandom);
      t.fix_second  = 6'($urandom);
    end else if (kind < 20) begin
      t.now_ms      = clock_ms + 32'($urandom_range(0, 29));
      t.fix_age_ms  = $urandom_range(0, 1500);
      t.pps_mark_ms = '0;
    end else begin
      clock_ms += ($urandom_range(0, 9) == 0) ? $urandom_range(1000, 4000)
                                              : $urandom_range(30, 700);
      t.now_ms     = clock_ms;
      t.fix_age_ms = ($urandom_range(0, 9) == 0) ? $urandom_range(1500, 3000)
                                                 : $urandom_range(0, 1500);
      commit = t.now_ms - t.fix_age_ms;
      sel    = $urandom_range(0, 19);
      if (sel < 8)       t.pps_mark_ms = '0;
      else if (sel < 17) t.pps_mark_ms = commit - $urandom_range(0, 999);
      else               t.pps_mark_ms = commit + $urandom_range(0, 999);
    end
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int unsigned stall;
    time_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_rx) begin
        stall   = HOLD_CYCLES;
        hold_rx = 1'b0;
      end else begin
        stall = draw_gap();
      end
      if (stall != 0) begin
        time_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      time_ch.ready <= 1'b1;
      do @(posedge clk); while (!time_ch.valid);
    end
  end

  initial begin
    item_t       t;
    logic        sync_on;
    logic [9:0]  nmea;
    logic [7:0]  slot;
    int unsigned n_items;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_SYNC_ENABLE;
    cfg_wdata           = '0;
    tick_ch.valid       = 1'b0;
    tick_ch.now_ms      = '0;
    tick_ch.fix_age_ms  = '0;
    tick_ch.fix_valid   = 1'b0;
    tick_ch.pps_mark_ms = '0;
    tick_ch.fix_year    = '0;
    tick_ch.fix_month   = '0;
    tick_ch.fix_day     = '0;
    tick_ch.fix_hour    = '0;
    tick_ch.fix_minute  = '0;
    tick_ch.fix_second  = '0;
    quiet               = 1'b0;
    hold_rx             = 1'b0;
    clock_ms            = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults first
    // edge moved back a second lands on zero, counts as no pps
    push_tick(mk_tick(1500, 800, 1, 1000, 2024, 2, 29, 23, 59, 59));
    push_tick(mk_tick(1510, 0, 1, 0, 2024, 2, 29, 23, 59, 59));
    push_tick(mk_tick(2000, 50, 1, 0, 2024, 3, 15, 12, 34, 56));
    push_tick(mk_tick(2600, 0, 0, 0, 2024, 3, 15, 12, 34, 56));
    push_tick(mk_tick(2900, 0, 0, 0, 2024, 3, 15, 12, 34, 56));
    push_tick(mk_tick(4100, 100, 1, 3900, 0, 0, 0, 0, 0, 0));
    // commit before the edge, late tick, commit past the second
    push_tick(mk_tick(5300, 200, 1, 5150, 99, 15, 31, 31, 63, 63));
    push_tick(mk_tick(6400, 30, 1, 0, 100, 13, 1, 0, 0, 0));
    push_tick(mk_tick(7400, 30, 1, 0, 1969, 12, 31, 23, 59, 59));
    push_tick(mk_tick(8400, 30, 1, 0, 1970, 1, 1, 0, 0, 0));
    push_tick(mk_tick(9400, 30, 1, 0, 2225, 14, 28, 0, 0, 0));
    push_tick(mk_tick(10400, 30, 1, 0, 4095, 2, 29, 12, 0, 0));
    push_tick(mk_tick(11400, 30, 1, 0, 2100, 3, 1, 0, 0, 0));
    push_tick(mk_tick(12400, 30, 1, 0, 2000, 3, 1, 0, 0, 0));
    push_tick(mk_tick(13400, 2500, 1, 0, 2000, 3, 1, 0, 0, 0));
    push_tick(mk_tick(16000, 2499, 1, 0, 2001, 6, 30, 8, 0, 0));
    push_tick(mk_tick(16400, 0, 1, 16400, 2001, 6, 30, 8, 0, 0));
    push_tick(mk_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF,
                      12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F));
    push_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_tick(mk_tick(17000, 40, 1, 16900, 2010, 7, 4, 10, 20, 30));
    drain();
    load_regs(1'b0, 10'd0, 8'd0);
    push_tick(mk_tick(18000, 30, 1, 0, 2011, 1, 1, 0, 0, 0));
    push_tick(mk_tick(18010, 30, 1, 0, 2011, 1, 1, 0, 0, 0));
    drain();
    load_regs(1'b1, 10'd1000, 8'd255);
    push_tick(mk_tick(20000, 30, 1, 0, 2038, 1, 19, 3, 14, 7));
    push_tick(mk_tick(21000, 30, 1, 20800, 2038, 1, 19, 3, 14, 8));
    push_tick(mk_tick(23500, 100, 1, 22000, 2038, 1, 19, 3, 14, 10));

    clock_ms = 32'd30000;
    for (int p = 0; p < 6; p++) begin
      drain();
      sync_on = 1'b1;
      nmea    = 10'($urandom_range(0, 1000));
      slot    = 8'($urandom_range(0, 255));
      n_items = 90;
      quiet   = 1'b0;
      case (p)
        1: begin
          nmea = 10'd1000;
          slot = 8'd255;
        end
        2: begin
          nmea  = 10'd0;
          slot  = 8'd0;
          quiet = 1'b1;
        end
        3: begin
          sync_on = 1'b0;
          n_items = 20;
        end
        5: begin
          // counter runs through the wrap
          n_items  = 70;
          clock_ms = 32'hFFFF_C000;
        end
        default: ;
      endcase
      load_regs(sync_on, nmea, slot);
      if (p == 1) hold_rx = 1'b1;
      for (int n = 0; n < n_items; n++) begin
        if (p == 4 && n == n_items / 2) drain();
        make_tick(t);
        push_tick(t);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_gnss_pps_time_discipline_top OK");
    end else begin
      $display("tb_gnss_pps_time_discipline_top NOT OK");
    end
    $finish;
  end

endmodule
